// ===== src/e2q_pkg.sv =====
// Package for the Euler angle to quaternion converter.
// Holds the fixed-point widths, the CORDIC constants and the arctangent table.
// Has no dependencies.
`timescale 1ns / 1ps
package e2q_pkg;

	// Number of CORDIC iterations, bounded by the size of the arctangent table.
	localparam int CORDIC_STAGES = 14;
	localparam int ATAN_ENTRIES  = 20;
	localparam int N_ITER = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

	// Angle accumulator is Q2.30 with headroom; sine and cosine are Q1.30.
	localparam int ANG_W = 34;
	localparam int SC_W  = 33;
	localparam int PROD_W = 2 * SC_W;
	localparam int SUM_W  = SC_W + 1;

	localparam int CORDIC_LAT  = N_ITER + 2;
	localparam int COMBINE_LAT = 3;
	localparam int TOTAL_LAT   = CORDIC_LAT + COMBINE_LAT;

	localparam logic signed [ANG_W-1:0] Q30_PI      = 34'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [SC_W-1:0]  CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [15:0]      Q14_ONE     = 16'sd16384;

	typedef logic signed [15:0]      angle_t;
	typedef logic signed [15:0]      q14_t;
	typedef logic signed [SC_W-1:0]  sc_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	// Sine and cosine of one half angle.
	typedef struct packed {
		sc_t s;
		sc_t c;
	} sincos_t;

	// atan(2^-i) in Q2.30, truncated.
	function automatic ang_t atan_q30(input int i);
		ang_t r;
		case (i)
			0:  r = 34'sh03243F6A8;
			1:  r = 34'sh01DAC6705;
			2:  r = 34'sh00FADBAFC;
			3:  r = 34'sh007F56EA6;
			4:  r = 34'sh003FEAB76;
			5:  r = 34'sh001FFD55B;
			6:  r = 34'sh000FFFAAA;
			7:  r = 34'sh0007FFF55;
			8:  r = 34'sh0003FFFEA;
			9:  r = 34'sh0001FFFFD;
			10: r = 34'sh0000FFFFF;
			11: r = 34'sh00007FFFF;
			12: r = 34'sh00003FFFF;
			13: r = 34'sh00001FFFF;
			14: r = 34'sh00000FFFF;
			15: r = 34'sh000007FFF;
			16: r = 34'sh000003FFF;
			17: r = 34'sh000001FFF;
			18: r = 34'sh000000FFF;
			19: r = 34'sh0000007FF;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Rounds a product of two Q1.30 values back to Q1.30.
	function automatic sc_t round_q30(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = (p + (PROD_W'(1) <<< 29)) >>> 30;
		return t[SC_W-1:0];
	endfunction

	// Rounds a Q1.30 sum to Q1.14 and saturates to plus or minus one.
	function automatic q14_t to_q14(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		q14_t o;
		r = (v + SUM_W'(32768)) >>> 16;
		if (r > SUM_W'(Q14_ONE))
			o = Q14_ONE;
		else if (r < -SUM_W'(Q14_ONE))
			o = -Q14_ONE;
		else
			o = r[15:0];
		return o;
	endfunction

endpackage

// ===== src/e2q_if.sv =====
// Channel interfaces of the converter: the angle triple and the quaternion.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
interface e2q_angle_if;
	logic valid;
	logic ready;
	e2q_pkg::angle_t roll_angle;
	e2q_pkg::angle_t pitch_angle;
	e2q_pkg::angle_t yaw_angle;
	modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
	modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if;
	logic valid;
	logic ready;
	e2q_pkg::q14_t quat_w;
	e2q_pkg::q14_t quat_x;
	e2q_pkg::q14_t quat_y;
	e2q_pkg::q14_t quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== src/e2q_cordic.sv =====
// One CORDIC lane: sine and cosine of half an angle, one iteration per stage.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_cordic (
	input  logic                  clk,
	input  logic                  en,
	input  e2q_pkg::angle_t       angle,
	output e2q_pkg::sincos_t      sc
);
	localparam int N = e2q_pkg::N_ITER;

	e2q_pkg::ang_t a_s [0:N];
	e2q_pkg::sc_t  x_s [0:N];
	e2q_pkg::sc_t  y_s [0:N];
	logic          flip_s [0:N];
	e2q_pkg::ang_t half_ang;
	e2q_pkg::sincos_t sc_q;

	// Half angle in Q2.30, folded into plus or minus pi/2.
	assign half_ang = {angle[15], angle, 17'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= e2q_pkg::CORDIC_GAIN;
			y_s[0] <= '0;
			if (half_ang > e2q_pkg::Q30_HALF_PI) begin
				a_s[0]    <= half_ang - e2q_pkg::Q30_PI;
				flip_s[0] <= 1'b1;
			end else if (half_ang < -e2q_pkg::Q30_HALF_PI) begin
				a_s[0]    <= half_ang + e2q_pkg::Q30_PI;
				flip_s[0] <= 1'b1;
			end else begin
				a_s[0]    <= half_ang;
				flip_s[0] <= 1'b0;
			end
		end
	end

	// Rotation stages with a fixed shift each.
	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[i+1] <= flip_s[i];
				if (!a_s[i][e2q_pkg::ANG_W-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - e2q_pkg::atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + e2q_pkg::atan_q30(i);
				end
			end
		end
	end

	// Undo the fold by negating both results.
	always_ff @(posedge clk) begin
		if (en) begin
			sc_q.s <= flip_s[N] ? -y_s[N] : y_s[N];
			sc_q.c <= flip_s[N] ? -x_s[N] : x_s[N];
		end
	end

	assign sc = sc_q;

	// The residual angle of the last stage is not needed.
	logic unused_res;
	assign unused_res = ^a_s[N];
endmodule

// ===== src/e2q_combine.sv =====
// Merging stage: forms the four quaternion components from the three lanes.
// Depends on e2q_pkg.
`timescale 1ns / 1ps
module e2q_combine (
	input  logic             clk,
	input  logic             en,
	input  e2q_pkg::sincos_t roll,
	input  e2q_pkg::sincos_t pitch,
	input  e2q_pkg::sincos_t yaw,
	output e2q_pkg::q14_t    quat_w,
	output e2q_pkg::q14_t    quat_x,
	output e2q_pkg::q14_t    quat_y,
	output e2q_pkg::q14_t    quat_z
);
	localparam int PW = e2q_pkg::PROD_W;

	e2q_pkg::sc_t crcp_s1, srsp_s1, srcp_s1, crsp_s1, cy_s1, sy_s1;
	e2q_pkg::sc_t t_s2 [0:7];
	e2q_pkg::q14_t w_s3, x_s3, y_s3, z_s3;

	function automatic e2q_pkg::sc_t mq(input e2q_pkg::sc_t a, input e2q_pkg::sc_t b);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b);
		return e2q_pkg::round_q30(p);
	endfunction

	// Roll and pitch pair products.
	always_ff @(posedge clk) begin
		if (en) begin
			crcp_s1 <= mq(roll.c, pitch.c);
			srsp_s1 <= mq(roll.s, pitch.s);
			srcp_s1 <= mq(roll.s, pitch.c);
			crsp_s1 <= mq(roll.c, pitch.s);
			cy_s1   <= yaw.c;
			sy_s1   <= yaw.s;
		end
	end

	// Triple products with the yaw terms.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2[0] <= mq(crcp_s1, cy_s1);
			t_s2[1] <= mq(srsp_s1, sy_s1);
			t_s2[2] <= mq(srcp_s1, cy_s1);
			t_s2[3] <= mq(crsp_s1, sy_s1);
			t_s2[4] <= mq(crsp_s1, cy_s1);
			t_s2[5] <= mq(srcp_s1, sy_s1);
			t_s2[6] <= mq(crcp_s1, sy_s1);
			t_s2[7] <= mq(srsp_s1, cy_s1);
		end
	end

	// Sums, rounding to Q1.14 and saturation.
	always_ff @(posedge clk) begin
		if (en) begin
			w_s3 <= e2q_pkg::to_q14(e2q_pkg::SUM_W'(t_s2[0]) + e2q_pkg::SUM_W'(t_s2[1]));
			x_s3 <= e2q_pkg::to_q14(e2q_pkg::SUM_W'(t_s2[2]) - e2q_pkg::SUM_W'(t_s2[3]));
			y_s3 <= e2q_pkg::to_q14(e2q_pkg::SUM_W'(t_s2[4]) + e2q_pkg::SUM_W'(t_s2[5]));
			z_s3 <= e2q_pkg::to_q14(e2q_pkg::SUM_W'(t_s2[6]) - e2q_pkg::SUM_W'(t_s2[7]));
		end
	end

	assign quat_w = w_s3;
	assign quat_x = x_s3;
	assign quat_y = y_s3;
	assign quat_z = z_s3;
endmodule

// ===== src/euler_to_quaternion_core.sv =====
// Top level of the Euler angle (Z-Y-X) to quaternion converter.
// Depends on e2q_pkg, e2q_if, e2q_cordic and e2q_combine.
//
// Usage:
// The angles channel takes one transaction of roll, pitch and yaw, each in
// radians as signed Q3.12. The quat channel delivers one transaction of w,
// x, y and z in signed Q1.14, saturated to plus or minus one, per input.
// Three CORDIC lanes form the half-angle sines and cosines side by side and a
// merging pipeline builds the triple products.
// From acceptance to a valid result, an input passes one fold stage, one
// stage per CORDIC iteration, one sign stage, and three product and rounding
// stages. Throughput is one transaction per cycle unless the output stalls.
// The pipeline moves as a whole: when a result waits at the output and the
// receiver holds ready low, every stage holds and angles.ready falls; while
// the output slot is empty or being taken, a new transaction is accepted.
// Reset clears all valid flags; no result is presented after reset until an
// input has gone through the whole pipeline.
`timescale 1ns / 1ps
module euler_to_quaternion_core (
	input  logic            clk,
	input  logic            arst_n,
	e2q_angle_if.sink       angles,
	e2q_quat_if.source      quat
);
	localparam int L = e2q_pkg::TOTAL_LAT;

	logic [L-1:0]     valid_q;
	logic             adv;
	e2q_pkg::sincos_t sc_roll, sc_pitch, sc_yaw;

	// Whole-pipeline advance whenever the output slot can move on.
	assign adv = !valid_q[L-1] || quat.ready;
	assign angles.ready = adv;
	assign quat.valid = valid_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[L-2:0], angles.valid};
		end
	end

	e2q_cordic u_roll (.clk(clk), .en(adv), .angle(angles.roll_angle), .sc(sc_roll));
	e2q_cordic u_pitch (.clk(clk), .en(adv), .angle(angles.pitch_angle), .sc(sc_pitch));
	e2q_cordic u_yaw (.clk(clk), .en(adv), .angle(angles.yaw_angle), .sc(sc_yaw));

	e2q_combine u_combine (
		.clk(clk), .en(adv),
		.roll(sc_roll), .pitch(sc_pitch), .yaw(sc_yaw),
		.quat_w(quat.quat_w), .quat_x(quat.quat_x),
		.quat_y(quat.quat_y), .quat_z(quat.quat_z)
	);
endmodule

// ===== src/e2q_checker.sv =====
// Port-level checks for the converter, bound to the top level.
// Depends on e2q_pkg and euler_to_quaternion_core.
`timescale 1ns / 1ps
module e2q_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input e2q_pkg::q14_t w,
	input e2q_pkg::q14_t x,
	input e2q_pkg::q14_t y,
	input e2q_pkg::q14_t z
);
	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({w, x, y, z}))
		else $error("result changed while stalled");

	// A stalled output blocks the input side.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// An empty output slot always lets the input in.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// Components stay within plus or minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (w <= e2q_pkg::Q14_ONE) && (w >= -e2q_pkg::Q14_ONE)
			&& (x <= e2q_pkg::Q14_ONE) && (x >= -e2q_pkg::Q14_ONE)
			&& (y <= e2q_pkg::Q14_ONE) && (y >= -e2q_pkg::Q14_ONE)
			&& (z <= e2q_pkg::Q14_ONE) && (z >= -e2q_pkg::Q14_ONE))
		else $error("component out of range");

	logic unused_iv;
	assign unused_iv = in_valid;
endmodule

bind euler_to_quaternion_core e2q_checker u_e2q_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(angles.valid), .in_ready(angles.ready),
	.out_valid(quat.valid), .out_ready(quat.ready),
	.w(quat.quat_w), .x(quat.quat_x), .y(quat.quat_y), .z(quat.quat_z)
);
